// ----- design/obme_pkg.sv -----
// Shared types and constants of the order book matching engine.
package obme_pkg;

    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_MODIFY = 2'd1,
        OP_CANCEL = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam int CASH_W     = 48;
    localparam int FILL_W     = 32;
    localparam int OPEN_OUT_W = 9;
    localparam int OUT_PRICE_W = 32;
    localparam int OUT_FIRM_W  = 4;

    localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
    localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};
    localparam logic [OPEN_OUT_W-1:0]    OPEN_OUT_MAX = '1;

    // Per-cell command from the sequencer.
    typedef struct packed {
        logic wr_en;     // write the slot at the shared address
        logic wr_valid;  // valid bit written with it
        logic place;     // firm seen, open count up
        logic drop;      // open count down
        logic fill;      // fill count up
        logic credit;    // balance up by the trade price
        logic debit;     // balance down by the trade price
    } t_cell_cmd;

endpackage

// ----- design/obme_in_if.sv -----
// Order channel: valid/ready with the order fields.
interface obme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  firm_index;
    logic [7:0]  symbol_index;
    logic        order_side;
    logic [31:0] price;

    modport source(output valid, operation, firm_index, symbol_index, order_side, price,
                   input ready);
    modport sink(input valid, operation, firm_index, symbol_index, order_side, price,
                 output ready);
endinterface

// ----- design/obme_out_if.sv -----
// Result channel: valid/ready with the result fields.
interface obme_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic               matched;
    logic [3:0]         counterparty;
    logic [31:0]        trade_price;
    logic               firm_known;
    logic [8:0]         firm_open_orders;
    logic [31:0]        firm_fills;
    logic signed [47:0] firm_balance;

    modport source(output valid, status, matched, counterparty, trade_price, firm_known,
                   firm_open_orders, firm_fills, firm_balance, input ready);
    modport sink(input valid, status, matched, counterparty, trade_price, firm_known,
                 firm_open_orders, firm_fills, firm_balance, output ready);
endinterface

// ----- design/order_book_match_engine.sv -----
// Order book matching engine: a row of per-firm cells and the item sequencer.
//
// Orders arrive on i_in (valid/ready, transfer when both are high) as new,
// modify, cancel or query, one result per order leaves on o_out.
// Each firm owns one cell holding its resting orders for every symbol and
// its totals. A new or repriced order is matched by a token passed from cell
// to cell, one cell a cycle, picking the best crossing opposite order.
// A matching order steps through accept, read, decide, the scan through all
// FIRMS cells with the trade update at its end, and result; cancel, query and
// rejected orders skip the scan, and an out-of-range order goes from accept to
// result. One order is processed at a time; the scan through the row sets the rate.
// After reset the slot memories are swept clear over all SYMBOLS addresses,
// during which i_in.ready stays low; totals and firm flags clear at once.
// The result sits in an output register; when the receiver stalls the
// engine holds it and stops the next order at its result step until taken.
module order_book_match_engine
    import obme_pkg::*;
#(
    parameter int FIRMS      = 16,
    parameter int SYMBOLS    = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obme_in_if.sink      i_in,
    obme_out_if.source   o_out
);
    localparam int FW = $clog2(FIRMS);
    localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int OW = $clog2(SYMBOLS + 1);
    localparam int PW = PRICE_BITS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_SCAN, S_RESP
    } t_state;

    t_state          r_state;
    t_op             r_op;
    logic [FW-1:0]   r_firm;
    logic [SW-1:0]   r_sym;
    logic            r_side;
    logic [PW-1:0]   r_price;
    logic            r_inrange;
    logic            r_status;
    logic            r_matched;
    logic [FW-1:0]   r_cp;
    logic [PW-1:0]   r_tp;
    logic            r_act_side;
    logic [SW-1:0]   r_clr_addr;

    logic                   r_o_valid;
    logic                   r_o_status;
    logic                   r_o_matched;
    logic [OUT_FIRM_W-1:0]  r_o_cp;
    logic [OUT_PRICE_W-1:0] r_o_tp;
    logic                   r_o_known;
    logic [OPEN_OUT_W-1:0]  r_o_open;
    logic [FILL_W-1:0]      r_o_fills;
    logic signed [CASH_W-1:0] r_o_cash;

    t_cell_cmd       w_cmd [FIRMS];
    logic [SW-1:0]   w_addr;
    logic            w_bus_side;
    logic [PW-1:0]   w_bus_price;
    logic            w_tok_v     [FIRMS+1];
    logic            w_tok_found [FIRMS+1];
    logic [FW-1:0]   w_tok_firm  [FIRMS+1];
    logic [PW-1:0]   w_tok_price [FIRMS+1];
    logic            w_slot_valid [FIRMS];
    logic            w_slot_side  [FIRMS];
    logic [PW-1:0]   w_slot_price [FIRMS];
    logic            w_seen  [FIRMS];
    logic [OW-1:0]   w_open  [FIRMS];
    logic [FILL_W-1:0] w_fills [FIRMS];
    logic signed [CASH_W-1:0] w_cash [FIRMS];

    logic            w_act_valid;
    logic            w_act_seen;
    logic            w_new_ok;
    logic            w_mod_ok;
    logic            w_can_ok;
    logic            w_scan_done;
    logic            w_trade;
    logic [FW-1:0]   w_buyer;
    logic [FW-1:0]   w_seller;
    logic [PW-1:0]   w_trade_price;
    logic            w_out_free;
    logic [47:0]     w_in_price_wide;
    logic [47:0]     w_tp_wide;

    assign w_act_valid = w_slot_valid[r_firm];
    assign w_act_seen  = w_seen[r_firm];
    assign w_new_ok    = (r_op == OP_NEW) && !w_act_valid;
    assign w_mod_ok    = (r_op == OP_MODIFY) && w_act_seen && w_act_valid;
    assign w_can_ok    = (r_op == OP_CANCEL) && w_act_seen && w_act_valid;
    assign w_scan_done = w_tok_v[FIRMS];
    assign w_trade     = (r_state == S_SCAN) && w_scan_done && w_tok_found[FIRMS];
    assign w_buyer     = (r_act_side == SIDE_BUY) ? r_firm : w_tok_firm[FIRMS];
    assign w_seller    = (r_act_side == SIDE_BUY) ? w_tok_firm[FIRMS] : r_firm;
    assign w_trade_price = (r_act_side == SIDE_BUY) ? w_tok_price[FIRMS] : r_price;
    assign w_out_free  = !r_o_valid || o_out.ready;
    assign w_in_price_wide = 48'(i_in.price);
    assign w_tp_wide   = 48'(r_tp);

    assign w_addr      = (r_state == S_CLEAR) ? r_clr_addr : r_sym;
    assign w_bus_side  = (r_op == OP_NEW) ? r_side : w_slot_side[r_firm];
    assign w_bus_price = (r_state == S_SCAN) ? w_trade_price : r_price;

    // Scan token enters the first cell when the acting order is in place.
    assign w_tok_v[0]     = (r_state == S_DECIDE) && (w_new_ok || w_mod_ok);
    assign w_tok_found[0] = 1'b0;
    assign w_tok_firm[0]  = '0;
    assign w_tok_price[0] = '0;

    always_comb begin
        for (int i = 0; i < FIRMS; i++) begin
            w_cmd[i] = '0;
            if (r_state == S_CLEAR) begin
                w_cmd[i].wr_en = 1'b1;
            end else if ((r_state == S_DECIDE) && (r_firm == FW'(i))) begin
                if (w_new_ok) begin
                    w_cmd[i].wr_en    = 1'b1;
                    w_cmd[i].wr_valid = 1'b1;
                    w_cmd[i].place    = 1'b1;
                end else if (w_mod_ok) begin
                    w_cmd[i].wr_en    = 1'b1;
                    w_cmd[i].wr_valid = 1'b1;
                end else if (w_can_ok) begin
                    w_cmd[i].wr_en = 1'b1;
                    w_cmd[i].drop  = 1'b1;
                end
            end else if (w_trade) begin
                if (w_buyer == FW'(i)) begin
                    w_cmd[i].wr_en = 1'b1;
                    w_cmd[i].drop  = 1'b1;
                    w_cmd[i].fill  = 1'b1;
                    w_cmd[i].debit = 1'b1;
                end
                if (w_seller == FW'(i)) begin
                    w_cmd[i].wr_en  = 1'b1;
                    w_cmd[i].drop   = 1'b1;
                    w_cmd[i].fill   = 1'b1;
                    w_cmd[i].credit = 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < FIRMS; g++) begin : g_cell
        obme_cell #(
            .FIRMS(FIRMS), .SYMBOLS(SYMBOLS), .PRICE_BITS(PRICE_BITS), .CELL_ID(g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_addr       (w_addr),
            .i_rd         (r_state == S_READ),
            .i_cmd        (w_cmd[g]),
            .i_bus_side   (w_bus_side),
            .i_bus_price  (w_bus_price),
            .i_act_firm   (r_firm),
            .i_act_side   (w_bus_side),
            .i_act_lim    (r_price),
            .i_tok_v      (w_tok_v[g]),
            .i_tok_found  (w_tok_found[g]),
            .i_tok_firm   (w_tok_firm[g]),
            .i_tok_price  (w_tok_price[g]),
            .o_tok_v      (w_tok_v[g+1]),
            .o_tok_found  (w_tok_found[g+1]),
            .o_tok_firm   (w_tok_firm[g+1]),
            .o_tok_price  (w_tok_price[g+1]),
            .o_slot_valid (w_slot_valid[g]),
            .o_slot_side  (w_slot_side[g]),
            .o_slot_price (w_slot_price[g]),
            .o_seen       (w_seen[g]),
            .o_open       (w_open[g]),
            .o_fills      (w_fills[g]),
            .o_cash       (w_cash[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_RESP)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SW'(1);
                    if (r_clr_addr == SW'(SYMBOLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op      <= t_op'(i_in.operation);
                        r_firm    <= FW'(i_in.firm_index);
                        r_sym     <= SW'(i_in.symbol_index);
                        r_side    <= i_in.order_side;
                        r_price   <= PW'(w_in_price_wide);
                        r_inrange <= (32'(i_in.firm_index) < FIRMS)
                                     && (32'(i_in.symbol_index) < SYMBOLS);
                        r_status  <= 1'b1;
                        r_matched <= 1'b0;
                        r_cp      <= '0;
                        r_tp      <= '0;
                        if ((32'(i_in.firm_index) < FIRMS)
                            && (32'(i_in.symbol_index) < SYMBOLS)) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_act_side <= w_bus_side;
                    if (r_op == OP_QUERY) begin
                        r_status <= !w_act_seen;
                    end else begin
                        r_status <= !(w_new_ok || w_mod_ok || w_can_ok);
                    end
                    r_state <= (w_new_ok || w_mod_ok) ? S_SCAN : S_RESP;
                end
                S_SCAN: begin
                    if (w_scan_done) begin
                        if (w_tok_found[FIRMS]) begin
                            r_matched <= 1'b1;
                            r_cp      <= w_tok_firm[FIRMS];
                            r_tp      <= w_trade_price;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_matched <= r_matched;
                        r_o_cp      <= OUT_FIRM_W'(r_cp);
                        r_o_tp      <= OUT_PRICE_W'(w_tp_wide);
                        if (r_inrange) begin
                            r_o_known <= w_seen[r_firm];
                            r_o_open  <= (32'(w_open[r_firm]) > 32'(OPEN_OUT_MAX))
                                         ? OPEN_OUT_MAX : OPEN_OUT_W'(w_open[r_firm]);
                            r_o_fills <= w_fills[r_firm];
                            r_o_cash  <= w_cash[r_firm];
                        end else begin
                            r_o_known <= 1'b0;
                            r_o_open  <= '0;
                            r_o_fills <= '0;
                            r_o_cash  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_o_valid;
    assign o_out.status           = r_o_status;
    assign o_out.matched          = r_o_matched;
    assign o_out.counterparty     = r_o_cp;
    assign o_out.trade_price      = r_o_tp;
    assign o_out.firm_known       = r_o_known;
    assign o_out.firm_open_orders = r_o_open;
    assign o_out.firm_fills       = r_o_fills;
    assign o_out.firm_balance     = r_o_cash;
endmodule

// ----- design/obme_cell.sv -----
// One firm's cell: its slot memory, its totals and one stage of the match scan.
module obme_cell
    import obme_pkg::*;
#(
    parameter int FIRMS      = 16,
    parameter int SYMBOLS    = 256,
    parameter int PRICE_BITS = 32,
    parameter int CELL_ID    = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] i_addr,
    input  logic                        i_rd,
    input  t_cell_cmd                   i_cmd,
    input  logic                        i_bus_side,
    input  logic [PRICE_BITS-1:0]       i_bus_price,
    input  logic [$clog2(FIRMS)-1:0]    i_act_firm,
    input  logic                        i_act_side,
    input  logic [PRICE_BITS-1:0]       i_act_lim,
    input  logic                        i_tok_v,
    input  logic                        i_tok_found,
    input  logic [$clog2(FIRMS)-1:0]    i_tok_firm,
    input  logic [PRICE_BITS-1:0]       i_tok_price,
    output logic                        o_tok_v,
    output logic                        o_tok_found,
    output logic [$clog2(FIRMS)-1:0]    o_tok_firm,
    output logic [PRICE_BITS-1:0]       o_tok_price,
    output logic                        o_slot_valid,
    output logic                        o_slot_side,
    output logic [PRICE_BITS-1:0]       o_slot_price,
    output logic                        o_seen,
    output logic [$clog2(SYMBOLS+1)-1:0] o_open,
    output logic [FILL_W-1:0]           o_fills,
    output logic signed [CASH_W-1:0]    o_cash
);
    localparam int FW = $clog2(FIRMS);
    localparam int OW = $clog2(SYMBOLS + 1);
    localparam int EW = PRICE_BITS + 2;
    localparam int SW2 = CASH_W + 2;

    logic [EW-1:0]          r_mem [SYMBOLS];
    logic [EW-1:0]          r_rdata;
    logic                   r_seen;
    logic [OW-1:0]          r_open;
    logic [FILL_W-1:0]      r_fills;
    logic signed [CASH_W-1:0] r_cash;
    logic                   r_tok_v;
    logic                   r_tok_found;
    logic [FW-1:0]          r_tok_firm;
    logic [PRICE_BITS-1:0]  r_tok_price;

    logic                   w_elig;
    logic                   w_take;
    logic signed [SW2-1:0]  w_delta;
    logic signed [SW2-1:0]  w_sum;
    logic signed [CASH_W-1:0] n_cash;

    assign o_slot_valid = r_rdata[EW-1];
    assign o_slot_side  = r_rdata[PRICE_BITS];
    assign o_slot_price = r_rdata[PRICE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= {i_cmd.wr_valid, i_bus_side, i_bus_price};
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // Scan stage: a resting order on the other side that crosses the acting limit.
    always_comb begin
        w_elig = o_slot_valid && (i_act_firm != FW'(CELL_ID)) && (o_slot_side != i_act_side)
                 && ((i_act_side == SIDE_BUY) ? (i_act_lim >= o_slot_price)
                                              : (i_act_lim <= o_slot_price));
        w_take = w_elig && (!i_tok_found || ((i_act_side == SIDE_BUY)
                 ? (o_slot_price < i_tok_price) : (o_slot_price >= i_tok_price)));
    end

    always_comb begin
        w_delta = $signed(SW2'(i_bus_price));
        if (i_cmd.debit) begin
            w_sum = SW2'(r_cash) - w_delta;
        end else begin
            w_sum = SW2'(r_cash) + w_delta;
        end
        if (w_sum > SW2'(CASH_MAX)) begin
            n_cash = CASH_MAX;
        end else if (w_sum < SW2'(CASH_MIN)) begin
            n_cash = CASH_MIN;
        end else begin
            n_cash = CASH_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_open  <= '0;
            r_fills <= '0;
            r_cash  <= '0;
            r_tok_v <= 1'b0;
        end else begin
            r_tok_v <= i_tok_v;
            if (i_cmd.place) begin
                r_seen <= 1'b1;
                r_open <= r_open + OW'(1);
            end else if (i_cmd.drop && (r_open != '0)) begin
                r_open <= r_open - OW'(1);
            end
            if (i_cmd.fill && (r_fills != '1)) begin
                r_fills <= r_fills + FILL_W'(1);
            end
            if (i_cmd.credit || i_cmd.debit) begin
                r_cash <= n_cash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_v) begin
            r_tok_found <= i_tok_found || w_take;
            r_tok_firm  <= w_take ? FW'(CELL_ID) : i_tok_firm;
            r_tok_price <= w_take ? o_slot_price : i_tok_price;
        end
    end

    assign o_tok_v     = r_tok_v;
    assign o_tok_found = r_tok_found;
    assign o_tok_firm  = r_tok_firm;
    assign o_tok_price = r_tok_price;
    assign o_seen      = r_seen;
    assign o_open      = r_open;
    assign o_fills     = r_fills;
    assign o_cash      = r_cash;
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the order book matching engine.
module testbench;
    import obme_pkg::*;

    localparam int NFIRMS = 16;
    localparam int NSYMS  = 256;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        t_op         op;
        logic [3:0]  firm;
        logic [7:0]  sym;
        logic        side;
        logic [31:0] price;
    } t_order;

    typedef struct packed {
        logic               status;
        logic               matched;
        logic [3:0]         cp;
        logic [31:0]        trade;
        logic               known;
        logic [8:0]         open;
        logic [31:0]        fills;
        logic signed [47:0] cash;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    obme_in_if  in_ch();
    obme_out_if out_ch();

    order_book_match_engine u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Book state as the engine should see it
    logic        book_valid [NFIRMS][NSYMS];
    logic        book_side  [NFIRMS][NSYMS];
    logic [31:0] book_price [NFIRMS][NSYMS];
    logic        seen       [NFIRMS];
    logic [8:0]  open_cnt   [NFIRMS];
    logic [31:0] fill_cnt   [NFIRMS];
    logic signed [47:0] cash_bal [NFIRMS];

    t_order   pending_orders[$];
    t_outcome expected_outcomes[$];
    int       mismatches = 0;
    bit       stim_done  = 0;
    bit       hold_off   = 0;

    function automatic logic signed [47:0] sat_add(logic signed [47:0] a, logic signed [49:0] d);
        logic signed [49:0] s;
        s = 50'(a) + d;
        if (s > 50'(CASH_MAX)) return CASH_MAX;
        if (s < 50'(CASH_MIN)) return CASH_MIN;
        return s[47:0];
    endfunction

    function automatic void drop_order(int f, int s);
        if (book_valid[f][s]) begin
            book_valid[f][s] = 0;
            if (open_cnt[f] > 0) open_cnt[f]--;
        end
    endfunction

    // Match the order resting at (f, s); fill in cp and trade on a hit
    function automatic bit cross_order(int f, int s, output logic [3:0] cp,
                                       output logic [31:0] trade);
        logic        side;
        logic [31:0] lim, best_p, p;
        bit          found;
        int          best_f, buyer, seller;
        side = book_side[f][s];
        lim = book_price[f][s];
        found = 0;
        best_f = 0;
        best_p = 0;
        cp = 0;
        trade = 0;
        for (int g = 0; g < NFIRMS; g++) begin
            if (g == f || !book_valid[g][s] || book_side[g][s] == side) continue;
            p = book_price[g][s];
            if (side == SIDE_BUY) begin
                if (lim < p) continue;
                if (!found || p < best_p) begin
                    found = 1; best_p = p; best_f = g;
                end
            end else begin
                if (lim > p) continue;
                if (!found || p >= best_p) begin
                    found = 1; best_p = p; best_f = g;
                end
            end
        end
        if (!found) return 0;
        trade  = (side == SIDE_BUY) ? best_p : lim;
        buyer  = (side == SIDE_BUY) ? f : best_f;
        seller = (side == SIDE_BUY) ? best_f : f;
        if (fill_cnt[buyer] != '1) fill_cnt[buyer]++;
        if (fill_cnt[seller] != '1) fill_cnt[seller]++;
        cash_bal[buyer]  = sat_add(cash_bal[buyer], -$signed({18'd0, trade}));
        cash_bal[seller] = sat_add(cash_bal[seller], $signed({18'd0, trade}));
        drop_order(f, s);
        drop_order(best_f, s);
        cp = best_f[3:0];
        return 1;
    endfunction

    function automatic t_outcome book_apply(t_order o);
        t_outcome r;
        int f, s;
        r = '0;
        r.status = 1;
        f = int'(o.firm);
        s = int'(o.sym);
        case (o.op)
            OP_NEW: begin
                if (!book_valid[f][s]) begin
                    seen[f] = 1;
                    book_valid[f][s] = 1;
                    book_side[f][s] = o.side;
                    book_price[f][s] = o.price;
                    open_cnt[f]++;
                    r.status = 0;
                    r.matched = cross_order(f, s, r.cp, r.trade);
                end
            end
            OP_MODIFY: begin
                if (seen[f] && book_valid[f][s]) begin
                    book_price[f][s] = o.price;
                    r.status = 0;
                    r.matched = cross_order(f, s, r.cp, r.trade);
                end
            end
            OP_CANCEL: begin
                if (seen[f] && book_valid[f][s]) begin
                    drop_order(f, s);
                    r.status = 0;
                end
            end
            default: r.status = !seen[f];
        endcase
        r.known = seen[f];
        r.open  = open_cnt[f];
        r.fills = fill_cnt[f];
        r.cash  = cash_bal[f];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    function automatic void queue_order(t_op op, int f, int s, bit side, logic [31:0] p);
        t_order o;
        o.op = op; o.firm = 4'(f); o.sym = 8'(s); o.side = side; o.price = p;
        pending_orders.insert(pending_orders.size(), o);
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        int f, s;
        logic [31:0] p;
        for (int a = 0; a < NFIRMS; a++) begin
            seen[a] = 0; open_cnt[a] = 0; fill_cnt[a] = 0; cash_bal[a] = 0;
            for (int b = 0; b < NSYMS; b++) book_valid[a][b] = 0;
        end
        // Directed: unknown firm, extremes, duplicates, ties, every operation
        queue_order(OP_QUERY, 0, 0, 0, 0);
        queue_order(OP_MODIFY, 3, 5, 0, 7);
        queue_order(OP_CANCEL, 3, 5, 0, 7);
        queue_order(OP_NEW, 15, 255, 1, 32'hFFFF_FFFF);
        queue_order(OP_NEW, 15, 255, 0, 1);
        queue_order(OP_NEW, 0, 255, 0, 32'hFFFF_FFFF);
        queue_order(OP_NEW, 1, 0, 1, 100);
        queue_order(OP_NEW, 2, 0, 1, 100);
        queue_order(OP_NEW, 3, 0, 0, 99);
        queue_order(OP_MODIFY, 3, 0, 0, 100);
        queue_order(OP_NEW, 4, 0, 0, 50);
        queue_order(OP_NEW, 5, 0, 0, 50);
        queue_order(OP_NEW, 6, 0, 1, 0);
        queue_order(OP_NEW, 7, 1, 0, 0);
        queue_order(OP_CANCEL, 7, 1, 0, 0);
        queue_order(OP_CANCEL, 7, 1, 0, 0);
        queue_order(OP_NEW, 8, 2, 1, 32'h8000_0000);
        queue_order(OP_NEW, 9, 2, 0, 32'hFFFF_FFFF);
        queue_order(OP_QUERY, 9, 0, 1, 0);
        queue_order(OP_QUERY, 14, 0, 0, 0);
        // Random: few symbols so orders cross often; some wide-range noise
        for (int n = 0; n < 600; n++) begin
            f = $urandom_range(0, 15);
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            p = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(1000 + $urandom_range(0, 40));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: queue_order(OP_NEW, f, s, 1'($urandom_range(0, 1)), p);
                5, 6:          queue_order(OP_MODIFY, f, s, 1'($urandom_range(0, 1)), p);
                7, 8:          queue_order(OP_CANCEL, f, s, 1'($urandom_range(0, 1)), p);
                default:       queue_order(OP_QUERY, f, s, 1'($urandom_range(0, 1)), p);
            endcase
        end
        stim_done = 1;
    end

    // Driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_outcomes.insert(expected_outcomes.size(),
                                         book_apply(pending_orders.pop_front()));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 0;
            end else if (pending_orders.size() > 0) begin
                in_ch.valid        <= 1;
                in_ch.operation    <= pending_orders[0].op;
                in_ch.firm_index   <= pending_orders[0].firm;
                in_ch.symbol_index <= pending_orders[0].sym;
                in_ch.order_side   <= pending_orders[0].side;
                in_ch.price        <= pending_orders[0].price;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                in_ch.valid <= 0;
            end
        end
    end

    initial begin
        in_ch.valid = 0;
        in_ch.operation = OP_NEW;
        in_ch.firm_index = 0;
        in_ch.symbol_index = 0;
        in_ch.order_side = 0;
        in_ch.price = 0;
        out_ch.ready = 0;
    end

    // Receiver stall pattern plus one long hold-off
    int accepted_out = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (accepted_out == 40 && hold_cnt < 600) begin
            hold_cnt++;
            out_ch.ready <= 0;
        end else if (accepted_out > 300 && accepted_out < 400) begin
            out_ch.ready <= 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            accepted_out++;
            if (expected_outcomes.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = expected_outcomes.pop_front();
                if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
                if (out_ch.matched !== w.matched) report("matched", out_ch.matched, w.matched);
                if (out_ch.counterparty !== w.cp) report("counterparty", out_ch.counterparty, w.cp);
                if (out_ch.trade_price !== w.trade) report("trade_price", out_ch.trade_price, w.trade);
                if (out_ch.firm_known !== w.known) report("firm_known", out_ch.firm_known, w.known);
                if (out_ch.firm_open_orders !== w.open)
                    report("firm_open_orders", out_ch.firm_open_orders, w.open);
                if (out_ch.firm_fills !== w.fills) report("firm_fills", out_ch.firm_fills, w.fills);
                if (out_ch.firm_balance !== w.cash)
                    report("firm_balance", out_ch.firm_balance, w.cash);
            end
        end
    end

    // Watchdog and end of run
    int idle_cycles = 0;
    int tail = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (stim_done && pending_orders.size() == 0 && !in_ch.valid
                     && expected_outcomes.size() == 0) begin
            tail <= tail + 1;
            if (tail == 40) begin
                if (mismatches == 0) begin
                    $display("SUCCESS");
                end else begin
                    $display("FAILURE");
                end
                $finish;
            end
        end
    end
endmodule
